[hdl/spectral_feature_expansion_unit_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef SPECTRAL_FEATURE_EXPANSION_UNIT_MACROS_SVH
`define SPECTRAL_FEATURE_EXPANSION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SFE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfe assertion failed");
`define SFE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("sfe assertion failed");
`else
`define SFE_ASSERT(name, clk, rst_n, prop)
`define SFE_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[hdl/sfe_pkg.sv]
package sfe_pkg;

    localparam int BAND_BITS_DEFAULT   = 16;
    localparam int BAND_COUNT          = 5;
    localparam int BAND_SEL_BITS       = $clog2(BAND_COUNT);
    localparam int NUM_FEATURES        = 23;
    localparam int INDEX_BITS          = 5;
    localparam int VALUE_BITS          = 34;
    localparam int FRAC_BITS           = 32;
    localparam int SOIL_BITS           = 16;
    localparam logic [SOIL_BITS-1:0] SOIL_RESET = 16'h8000;
    localparam int RATIO_COUNT         = 3;
    localparam int DIV_STEPS_PER_CYCLE = 2;
    localparam int DIV_CYCLES          = VALUE_BITS / DIV_STEPS_PER_CYCLE;
    localparam int DIV_COUNT_BITS      = $clog2(DIV_CYCLES + 1);
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [INDEX_BITS-1:0] FIRST_PAIR_INDEX  = 5'd10;
    localparam logic [INDEX_BITS-1:0] FIRST_RATIO_INDEX = 5'd20;
    localparam logic [INDEX_BITS-1:0] LAST_INDEX        = 5'd22;

    localparam logic [BAND_SEL_BITS-1:0] BAND_RED  = 3'd2;
    localparam logic [BAND_SEL_BITS-1:0] BAND_NIR  = 3'd3;
    localparam logic [BAND_SEL_BITS-1:0] BAND_SWIR = 3'd4;

    localparam logic [BAND_SEL_BITS-1:0] RATIO_NDVI = 3'd0;
    localparam logic [BAND_SEL_BITS-1:0] RATIO_NDWI = 3'd1;
    localparam logic [BAND_SEL_BITS-1:0] RATIO_SAVI = 3'd2;

    typedef enum logic [1:0] {
        KIND_BAND    = 2'd0,
        KIND_PRODUCT = 2'd1,
        KIND_RATIO   = 2'd2
    } t_feature_kind;

    typedef struct packed {
        t_feature_kind              kind;
        logic [BAND_SEL_BITS-1:0]   op_a;
        logic [BAND_SEL_BITS-1:0]   op_b;
    } t_feature_sel;

    function automatic t_feature_sel feature_select(input logic [INDEX_BITS-1:0] idx);
        t_feature_sel sel;
        logic [INDEX_BITS-1:0] rel;
        sel = '{kind: KIND_RATIO, op_a: RATIO_NDVI, op_b: RATIO_NDVI};
        rel = idx - FIRST_RATIO_INDEX;
        if (idx < FIRST_PAIR_INDEX) begin
            sel.kind = idx[0] ? KIND_PRODUCT : KIND_BAND;
            sel.op_a = idx[3:1];
            sel.op_b = idx[3:1];
        end else if (idx < FIRST_RATIO_INDEX) begin
            sel.kind = KIND_PRODUCT;
            unique case (idx)
                5'd10:   begin sel.op_a = 3'd0; sel.op_b = 3'd1; end
                5'd11:   begin sel.op_a = 3'd0; sel.op_b = 3'd2; end
                5'd12:   begin sel.op_a = 3'd0; sel.op_b = 3'd3; end
                5'd13:   begin sel.op_a = 3'd0; sel.op_b = 3'd4; end
                5'd14:   begin sel.op_a = 3'd1; sel.op_b = 3'd2; end
                5'd15:   begin sel.op_a = 3'd1; sel.op_b = 3'd3; end
                5'd16:   begin sel.op_a = 3'd1; sel.op_b = 3'd4; end
                5'd17:   begin sel.op_a = 3'd2; sel.op_b = 3'd3; end
                5'd18:   begin sel.op_a = 3'd2; sel.op_b = 3'd4; end
                default: begin sel.op_a = 3'd3; sel.op_b = 3'd4; end
            endcase
        end else begin
            sel.op_a = rel[BAND_SEL_BITS-1:0];
        end
        return sel;
    endfunction

endpackage

[hdl/sfe_channels.sv]
interface sfe_pixel_if #(parameter int BAND_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [BAND_BITS-1:0] blue_band;
    logic [BAND_BITS-1:0] green_band;
    logic [BAND_BITS-1:0] red_band;
    logic [BAND_BITS-1:0] near_infrared_band;
    logic [BAND_BITS-1:0] shortwave_infrared_band;

    modport source (output valid, blue_band, green_band, red_band, near_infrared_band,
                    shortwave_infrared_band, input ready);
    modport sink (input valid, blue_band, green_band, red_band, near_infrared_band,
                  shortwave_infrared_band, output ready);
endinterface

interface sfe_feature_if;
    logic               valid;
    logic               ready;
    logic [4:0]         feat_idx;
    logic signed [33:0] feature_value;
    logic               last_feature;

    modport source (output valid, feat_idx, feature_value, last_feature, input ready);
    modport sink (input valid, feat_idx, feature_value, last_feature, output ready);
endinterface

interface sfe_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] soil_factor;

    modport source (output valid, soil_factor, input ready);
    modport sink (input valid, soil_factor, output ready);
endinterface

[hdl/spectral_feature_expansion_unit.sv]
// Expands one pixel of five unsigned reflectance bands into 23 signed Q2.32 features: each
// band and its square, the ten pairwise products, then NDVI, NDWI and SAVI, the last one
// flagged. A front queue of two pixels takes new transactions while the back stage works,
// and the back stage loads the next pixel as it sends the last feature of the one before;
// the result channel moves one feature per cycle while the receiver is ready. The three
// ratios come from three dividers that retire two quotient bits a cycle, hidden behind the
// products. Each feature leaves through a registered output stage. The soil factor resets
// to 0.5 and is captured with each pixel when it is queued.
`include "spectral_feature_expansion_unit_macros.svh"

module spectral_feature_expansion_unit
    import sfe_pkg::*;
#(
    parameter int BAND_BITS = BAND_BITS_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sfe_cfg_if.sink        i_cfg,
    sfe_pixel_if.sink      i_pixel,
    sfe_feature_if.source  o_feature
);

    logic                                 q_valid;
    logic                                 q_ready;
    logic [BAND_COUNT-1:0][BAND_BITS-1:0] q_pix;
    logic [SOIL_BITS-1:0]                 q_soil;

    sfe_front #(.BAND_BITS(BAND_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_pixel   (i_pixel),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_pix   (q_pix),
        .o_q_soil  (q_soil)
    );

    sfe_back #(.BAND_BITS(BAND_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_pix   (q_pix),
        .i_q_soil  (q_soil),
        .o_feature (o_feature)
    );

    `SFE_ASSERT(a_queue_holds, i_clk, i_rst_n, q_valid && !q_ready |=> q_valid)
    `SFE_ASSERT(a_last_is_savi, i_clk, i_rst_n, o_feature.valid && o_feature.last_feature |-> o_feature.feat_idx == LAST_INDEX)
    `SFE_ASSERT(a_index_steps, i_clk, i_rst_n, o_feature.valid && o_feature.ready && !o_feature.last_feature |=> !o_feature.valid || o_feature.feat_idx == $past(o_feature.feat_idx) + 5'd1)
    `SFE_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_feature.valid && !q_valid)

endmodule

[hdl/sfe_front.sv]
module sfe_front
    import sfe_pkg::*;
#(
    parameter int BAND_BITS = BAND_BITS_DEFAULT
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    sfe_cfg_if.sink                                 i_cfg,
    sfe_pixel_if.sink                               i_pixel,
    output logic                                    o_q_valid,
    input  logic                                    i_q_ready,
    output logic [BAND_COUNT-1:0][BAND_BITS-1:0]    o_q_pix,
    output logic [SOIL_BITS-1:0]                    o_q_soil
);

    localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [SOIL_BITS-1:0]                   r_soil_factor;
    logic [BAND_COUNT-1:0][BAND_BITS-1:0]   r_entry_pix [QUEUE_DEPTH];
    logic [SOIL_BITS-1:0]                   r_entry_soil [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]                    r_wr_ptr;
    logic [PTR_BITS-1:0]                    r_rd_ptr;
    logic [COUNT_BITS-1:0]                  r_count;
    logic                                   push;
    logic                                   pop;

    assign i_cfg.ready   = 1'b1;
    assign i_pixel.ready = (r_count != COUNT_BITS'(QUEUE_DEPTH));
    assign push          = i_pixel.valid && i_pixel.ready;
    assign pop           = o_q_valid && i_q_ready;
    assign o_q_valid     = (r_count != '0);
    assign o_q_pix       = r_entry_pix[r_rd_ptr];
    assign o_q_soil      = r_entry_soil[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soil_factor <= SOIL_RESET;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_soil_factor <= i_cfg.soil_factor;
            end
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry_pix[r_wr_ptr]  <= {i_pixel.shortwave_infrared_band,
                                       i_pixel.near_infrared_band,
                                       i_pixel.red_band,
                                       i_pixel.green_band,
                                       i_pixel.blue_band};
            r_entry_soil[r_wr_ptr] <= r_soil_factor;
        end
    end

endmodule

[hdl/sfe_divider.sv]
module sfe_divider
    import sfe_pkg::*;
#(
    parameter int NUM_BITS = 33,
    parameter int DEN_BITS = 34
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NUM_BITS-1:0]          i_num,
    input  logic [DEN_BITS-1:0]          i_den,
    input  logic                         i_negative,
    output logic                         o_done,
    output logic signed [VALUE_BITS-1:0] o_quotient
);

    logic                       r_busy;
    logic                       r_done;
    logic [DIV_COUNT_BITS-1:0]  r_left;
    logic [DEN_BITS-1:0]        r_rem;
    logic [DEN_BITS-1:0]        r_den;
    logic [VALUE_BITS-1:0]      r_low;
    logic [VALUE_BITS-1:0]      r_quot;
    logic                       r_negative;
    logic                       r_den_zero;
    logic [DEN_BITS-1:0]        n_rem;
    logic [VALUE_BITS-1:0]      n_low;
    logic [VALUE_BITS-1:0]      n_quot;

    always_comb begin
        logic [DEN_BITS:0] trial;
        n_rem  = r_rem;
        n_low  = r_low;
        n_quot = r_quot;
        for (int k = 0; k < DIV_STEPS_PER_CYCLE; k++) begin
            trial = {n_rem, n_low[VALUE_BITS-1]};
            n_low = {n_low[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial  = trial - {1'b0, r_den};
                n_quot = {n_quot[VALUE_BITS-2:0], 1'b1};
            end else begin
                n_quot = {n_quot[VALUE_BITS-2:0], 1'b0};
            end
            n_rem = trial[DEN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_left <= DIV_COUNT_BITS'(DIV_CYCLES);
        end else if (r_busy) begin
            r_left <= r_left - 1'b1;
            if (r_left == DIV_COUNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem      <= DEN_BITS'(i_num >> 2);
            r_low      <= {i_num[1:0], {FRAC_BITS{1'b0}}};
            r_quot     <= '0;
            r_den      <= i_den;
            r_negative <= i_negative;
            r_den_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= n_low;
            r_quot <= n_quot;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_den_zero ? '0 :
                        (r_negative ? -$signed(r_quot) : $signed(r_quot));

endmodule

[hdl/sfe_back.sv]
module sfe_back
    import sfe_pkg::*;
#(
    parameter int BAND_BITS = BAND_BITS_DEFAULT
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_q_valid,
    output logic                                    o_q_ready,
    input  logic [BAND_COUNT-1:0][BAND_BITS-1:0]    i_q_pix,
    input  logic [SOIL_BITS-1:0]                    i_q_soil,
    sfe_feature_if.source                           o_feature
);

    localparam int NUM_BITS  = BAND_BITS + SOIL_BITS + 1;
    localparam int DEN_BITS  = BAND_BITS + SOIL_BITS + 2;
    localparam int MULT_BITS = SOIL_BITS + 1;

    logic [BAND_COUNT-1:0][BAND_BITS-1:0] r_pix;
    logic [SOIL_BITS-1:0]                 r_soil;
    logic                                 r_busy;
    logic                                 r_setup;
    logic [INDEX_BITS-1:0]                r_idx;
    logic                                 r_out_valid;
    logic [INDEX_BITS-1:0]                r_out_index;
    logic signed [VALUE_BITS-1:0]         r_out_value;
    logic                                 r_out_last;

    t_feature_sel                         sel;
    logic                                 out_free;
    logic                                 adv;
    logic                                 at_last;
    logic                                 load;
    logic [RATIO_COUNT-1:0]               div_done;
    logic signed [VALUE_BITS-1:0]         quot [RATIO_COUNT];
    logic [BAND_BITS-1:0]                 op_a;
    logic [BAND_BITS-1:0]                 op_b;
    logic [2*BAND_BITS-1:0]               prod;
    logic [BAND_BITS+FRAC_BITS-1:0]       band_wide;
    logic [2*BAND_BITS+FRAC_BITS-1:0]     prod_wide;
    logic signed [VALUE_BITS-1:0]         value;

    logic [BAND_BITS-1:0]                 red;
    logic [BAND_BITS-1:0]                 nir;
    logic [BAND_BITS-1:0]                 swir;
    logic [BAND_BITS-1:0]                 mag_red;
    logic [BAND_BITS-1:0]                 mag_swir;
    logic [BAND_BITS:0]                   sum_red;
    logic [BAND_BITS:0]                   sum_swir;
    logic [MULT_BITS-1:0]                 savi_mult;
    logic [NUM_BITS-1:0]                  savi_num;
    logic [DEN_BITS-1:0]                  savi_den;
    logic                                 neg_red;
    logic                                 neg_swir;

    assign sel      = feature_select(r_idx);
    assign out_free = !r_out_valid || o_feature.ready;
    assign adv      = r_busy && out_free && (sel.kind != KIND_RATIO || (&div_done));
    assign at_last  = (r_idx == LAST_INDEX);
    assign o_q_ready = !r_busy || (adv && at_last);
    assign load     = i_q_valid && o_q_ready;

    assign op_a      = r_pix[sel.op_a];
    assign op_b      = r_pix[sel.op_b];
    assign prod      = op_a * op_b;
    assign band_wide = {op_a, {FRAC_BITS{1'b0}}};
    assign prod_wide = {prod, {FRAC_BITS{1'b0}}};

    always_comb begin
        case (sel.kind)
            KIND_BAND: begin
                value = $signed({2'b00, band_wide[BAND_BITS+FRAC_BITS-1:BAND_BITS]});
            end
            KIND_PRODUCT: begin
                value = $signed({2'b00,
                                 prod_wide[2*BAND_BITS+FRAC_BITS-1:2*BAND_BITS]});
            end
            default: begin
                if (sel.op_a == RATIO_NDVI) begin
                    value = quot[0];
                end else if (sel.op_a == RATIO_NDWI) begin
                    value = quot[1];
                end else begin
                    value = quot[2];
                end
            end
        endcase
    end

    assign red       = r_pix[BAND_RED];
    assign nir       = r_pix[BAND_NIR];
    assign swir      = r_pix[BAND_SWIR];
    assign neg_red   = red > nir;
    assign neg_swir  = swir > nir;
    assign mag_red   = neg_red ? red - nir : nir - red;
    assign mag_swir  = neg_swir ? swir - nir : nir - swir;
    assign sum_red   = {1'b0, nir} + {1'b0, red};
    assign sum_swir  = {1'b0, nir} + {1'b0, swir};
    assign savi_mult = {1'b1, {SOIL_BITS{1'b0}}} + {1'b0, r_soil};
    assign savi_num  = NUM_BITS'(mag_red) * NUM_BITS'(savi_mult);
    assign savi_den  = {1'b0, sum_red, {SOIL_BITS{1'b0}}}
                     + DEN_BITS'({r_soil, {BAND_BITS{1'b0}}});

    sfe_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div_ndvi (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_setup),
        .i_num      (NUM_BITS'(mag_red)),
        .i_den      (DEN_BITS'(sum_red)),
        .i_negative (neg_red),
        .o_done     (div_done[0]),
        .o_quotient (quot[0])
    );

    sfe_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div_ndwi (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_setup),
        .i_num      (NUM_BITS'(mag_swir)),
        .i_den      (DEN_BITS'(sum_swir)),
        .i_negative (neg_swir),
        .o_done     (div_done[1]),
        .o_quotient (quot[1])
    );

    sfe_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div_savi (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_setup),
        .i_num      (savi_num),
        .i_den      (savi_den),
        .i_negative (neg_red),
        .o_done     (div_done[2]),
        .o_quotient (quot[2])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_setup     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_setup <= load;
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv) begin
                r_idx <= r_idx + 1'b1;
                if (at_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_feature.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pix  <= i_q_pix;
            r_soil <= i_q_soil;
        end
        if (adv) begin
            r_out_index <= r_idx;
            r_out_value <= value;
            r_out_last  <= at_last;
        end
    end

    assign o_feature.valid         = r_out_valid;
    assign o_feature.feat_idx      = r_out_index;
    assign o_feature.feature_value = r_out_value;
    assign o_feature.last_feature  = r_out_last;

endmodule
